FILE: rtl/core/cma_pkg.sv
// Shared constants and types for the centered moving average block.
package cma_pkg;

    localparam int WL_W        = 7;
    localparam int RECIP_W     = 17;
    localparam int H_W         = WL_W - 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int FRAC_BITS   = 16;
    localparam int ROUND_BIAS  = 32768;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RECIPROCAL = 2'd1;

    localparam logic [WL_W-1:0]    WL_RESET    = 7'd1;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 17'd65536;

    typedef enum logic {
        FRONT_RUN,
        FRONT_FLUSH
    } front_state_t;

    typedef struct packed {
        logic              nonempty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

FILE: rtl/core/cma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/cma_queue.sv
// Short FIFO between the accumulate front end and the scaling back end.
module cma_queue #(
    parameter int WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output cma_pkg::queue_status_t status
);

    import cma_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data        = mem_reg[rd_ptr_reg];
    assign status.nonempty = (count_reg != '0);
    assign status.count    = count_reg;

endmodule

FILE: rtl/core/cma_front.sv
// Front end: accepts samples, keeps the history and running sum, sequences the flush.
module cma_front #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 23,
    parameter int ADDR_W      = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cma_pkg::WL_W-1:0]      window_length,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          final_sample,
    input  cma_pkg::queue_status_t        q_status,
    output logic                          ram_wr_en,
    output logic [ADDR_W-1:0]             ram_wr_addr,
    output logic [SAMPLE_BITS-1:0]        ram_wr_data,
    output logic [ADDR_W-1:0]             ram_rd_addr,
    input  logic [SAMPLE_BITS-1:0]        ram_rd_data,
    output logic                          push,
    output logic [SUM_W:0]                push_data
);

    import cma_pkg::*;

    localparam int HMAX    = MAX_WINDOW / 2;
    localparam int CNT_CAP = 2 * MAX_WINDOW - 1;
    localparam int CNT_W   = $clog2(2 * MAX_WINDOW);
    localparam int K_W     = H_W + 1;

    front_state_t state_reg, state_next;

    logic [ADDR_W-1:0]       wp_reg, wp_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [H_W-1:0]          fj_reg, fj_next;
    logic [H_W-1:0]          fm_reg, fm_next;
    logic [H_W-1:0]          fh_reg, fh_next;
    logic                    fsub_reg, fsub_next;
    logic [CNT_W-1:0]        fcnt_reg, fcnt_next;

    logic                         b_valid_reg;
    logic signed [SAMPLE_BITS-1:0] b_x_reg;
    logic                         b_sub_reg;
    logic                         b_emit_reg;
    logic                         b_last_reg;

    logic [H_W-1:0]                h;
    logic [H_W-1:0]                m_run;
    logic [CNT_W-1:0]              cnt_new;
    logic                          credit_ok;
    logic                          accept;
    logic [K_W-1:0]                k;
    logic                          flush_sub;
    logic [ADDR_W-1:0]             run_addr;
    logic [ADDR_W-1:0]             flush_addr;
    logic                          issue;
    logic signed [SAMPLE_BITS-1:0] op_x;
    logic                          op_sub;
    logic                          op_emit;
    logic                          op_last;
    logic signed [SUM_W-1:0]       x_ext;
    logic signed [SUM_W-1:0]       sub_ext;
    logic signed [SUM_W-1:0]       val;

    always_comb
    begin
        h = window_length[WL_W-1:1];
        if (int'(h) > HMAX)
        begin
            h = H_W'(HMAX);
        end
    end

    assign m_run      = (int'(cnt_reg) < int'(h)) ? H_W'(cnt_reg) : h;
    assign cnt_new    = (int'(cnt_reg) < CNT_CAP) ? cnt_reg + 1'b1 : CNT_W'(CNT_CAP);
    assign credit_ok  = (int'(q_status.count) + int'(b_valid_reg)) < QUEUE_DEPTH;
    assign accept     = in_valid && in_ready;
    assign k          = {fh_reg, 1'b0} - K_W'(fj_reg) + 1'b1;
    assign flush_sub  = fsub_reg && (int'(k) < int'(fcnt_reg));
    assign run_addr   = wp_reg - ADDR_W'({h, 1'b0}) - 1'b1;
    assign flush_addr = wp_reg - ADDR_W'(k) - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FRONT_RUN:
            begin
                if (accept && final_sample && (m_run != '0))
                begin
                    state_next = FRONT_FLUSH;
                end
            end
            FRONT_FLUSH:
            begin
                if (credit_ok && (fj_reg == fm_reg))
                begin
                    state_next = FRONT_RUN;
                end
            end
            default: state_next = FRONT_RUN;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        issue       = 1'b0;
        op_x        = '0;
        op_sub      = 1'b0;
        op_emit     = 1'b0;
        op_last     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_addr = run_addr;
        wp_next     = wp_reg;
        cnt_next    = cnt_reg;
        fj_next     = fj_reg;
        fm_next     = fm_reg;
        fh_next     = fh_reg;
        fsub_next   = fsub_reg;
        fcnt_next   = fcnt_reg;
        case (state_reg)
            FRONT_RUN:
            begin
                in_ready = credit_ok;
                if (accept)
                begin
                    issue     = 1'b1;
                    ram_wr_en = 1'b1;
                    op_x      = sample;
                    op_sub    = int'(cnt_reg) >= 2 * int'(h) + 1;
                    op_emit   = final_sample || (int'(cnt_new) > int'(h));
                    op_last   = final_sample && (m_run == '0);
                    wp_next   = wp_reg + 1'b1;
                    cnt_next  = final_sample ? '0 : cnt_new;
                    if (final_sample)
                    begin
                        fj_next   = H_W'(1);
                        fm_next   = m_run;
                        fh_next   = h;
                        fsub_next = int'(cnt_reg) >= int'(h);
                        fcnt_next = cnt_new;
                    end
                end
            end
            FRONT_FLUSH:
            begin
                ram_rd_addr = flush_addr;
                if (credit_ok)
                begin
                    issue   = 1'b1;
                    op_sub  = flush_sub;
                    op_emit = 1'b1;
                    op_last = (fj_reg == fm_reg);
                    fj_next = fj_reg + 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign ram_wr_addr = wp_reg;
    assign ram_wr_data = sample;

    // accumulate stage: history read data lines up with the registered op
    assign x_ext   = {{(SUM_W - SAMPLE_BITS){b_x_reg[SAMPLE_BITS-1]}}, b_x_reg};
    assign sub_ext = b_sub_reg
                   ? {{(SUM_W - SAMPLE_BITS){ram_rd_data[SAMPLE_BITS-1]}}, ram_rd_data}
                   : '0;
    assign val       = sum_reg + x_ext - sub_ext;
    assign push      = b_valid_reg && b_emit_reg;
    assign push_data = {val, b_last_reg};

    always_comb
    begin
        sum_next = sum_reg;
        if (b_valid_reg)
        begin
            sum_next = b_last_reg ? '0 : val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FRONT_RUN;
            wp_reg      <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            fj_reg      <= '0;
            fm_reg      <= '0;
            fh_reg      <= '0;
            fsub_reg    <= 1'b0;
            fcnt_reg    <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            fj_reg      <= fj_next;
            fm_reg      <= fm_next;
            fh_reg      <= fh_next;
            fsub_reg    <= fsub_next;
            fcnt_reg    <= fcnt_next;
            b_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_x_reg    <= op_x;
            b_sub_reg  <= op_sub;
            b_emit_reg <= op_emit;
            b_last_reg <= op_last;
        end
    end

endmodule

FILE: rtl/core/cma_back.sv
// Back end: scales queued sums by the reciprocal, rounds, saturates and drives the output.
module cma_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 23
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cma_pkg::RECIP_W-1:0]   window_reciprocal,
    input  cma_pkg::queue_status_t        q_status,
    input  logic [SUM_W:0]                pop_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] average,
    output logic                          final_result
);

    import cma_pkg::*;

    localparam int P_W = SUM_W + RECIP_W + 1;
    localparam logic signed [P_W-1:0] SAT_HI = P_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [P_W-1:0] SAT_LO = ~SAT_HI;

    logic                          m_valid_reg, m_valid_next;
    logic signed [P_W-1:0]         m_prod_reg;
    logic                          m_last_reg;
    logic                          o_valid_reg, o_valid_next;
    logic signed [SAMPLE_BITS-1:0] o_avg_reg;
    logic                          o_last_reg;

    logic                          o_take;
    logic                          m_take;
    logic signed [SUM_W-1:0]       sum_in;
    logic signed [RECIP_W:0]       recip_s;
    logic signed [P_W-1:0]         prod;
    logic signed [P_W-1:0]         rnd;
    logic signed [SAMPLE_BITS-1:0] sat;

    assign o_take = !o_valid_reg || out_ready;
    assign m_take = !m_valid_reg || o_take;
    assign pop    = q_status.nonempty && m_take;

    assign sum_in  = pop_data[SUM_W:1];
    assign recip_s = {1'b0, window_reciprocal};
    assign prod    = P_W'(sum_in) * P_W'(recip_s);

    assign rnd = (m_prod_reg + P_W'(ROUND_BIAS)) >>> FRAC_BITS;

    always_comb
    begin
        if (rnd > SAT_HI)
        begin
            sat = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (rnd < SAT_LO)
        begin
            sat = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = rnd[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        m_valid_next = m_take ? pop : m_valid_reg;
        o_valid_next = o_take ? m_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_prod_reg <= prod;
            m_last_reg <= pop_data[0];
        end
        if (o_take && m_valid_reg)
        begin
            o_avg_reg  <= sat;
            o_last_reg <= m_last_reg;
        end
    end

    assign out_valid    = o_valid_reg;
    assign average      = o_avg_reg;
    assign final_result = o_last_reg;

endmodule

FILE: rtl/core/centered_moving_average.sv
// Centered moving average filter over a signed sample stream, window sum scaled by a Q1.16 reciprocal.
//
// Takes one sample per clock and delivers one average per clock while the
// input is not held off and out_ready is high. A result passes from the edge
// that accepts the sample completing its span through the accumulate stage
// into the queue, then the multiply register and the round/saturate output
// register. The sample marked final flushes min(n, h)+1 results (n = earlier
// samples of the signal, h = window_length/2, clamped to MAX_WINDOW/2), one
// per cycle while the queue has room; during the flush the input is held off,
// since every flushed result needs one read of the history RAM. The input also
// stalls while the queue between front and back end is full. The history needs
// no clearing pass: a fill count masks entries from an earlier signal. Write
// the configuration registers only while no transaction is in flight.
module centered_moving_average #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_enable,
    input  logic [cma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cma_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    input  logic                             final_sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [SAMPLE_BITS-1:0]    average,
    output logic                             final_result
);

    import cma_pkg::*;

    localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W    = $clog2(MAX_WINDOW + 2);
    localparam int RAM_DEPTH = 1 << ADDR_W;

    logic [WL_W-1:0]    wl_reg, wl_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;

    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [SAMPLE_BITS-1:0] ram_wr_data;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [SAMPLE_BITS-1:0] ram_rd_data;

    logic            q_push;
    logic [SUM_W:0]  q_push_data;
    logic            q_pop;
    logic [SUM_W:0]  q_pop_data;
    queue_status_t   q_status;

    always_comb
    begin
        wl_next    = wl_reg;
        recip_next = recip_reg;
        if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH:     wl_next    = cfg_data[WL_W-1:0];
                CFG_WINDOW_RECIPROCAL: recip_next = cfg_data[RECIP_W-1:0];
                default:               wl_next    = wl_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg    <= WL_RESET;
            recip_reg <= RECIP_RESET;
        end
        else
        begin
            wl_reg    <= wl_next;
            recip_reg <= recip_next;
        end
    end

    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    cma_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (wl_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .final_sample  (final_sample),
        .q_status      (q_status),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data),
        .push          (q_push),
        .push_data     (q_push_data)
    );

    cma_queue #(
        .WIDTH (SUM_W + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    cma_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .window_reciprocal (recip_reg),
        .q_status          (q_status),
        .pop_data          (q_pop_data),
        .pop               (q_pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .average           (average),
        .final_result      (final_result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_status.count < QCNT_W'(QUEUE_DEPTH)))
        else $error("queue push with no free entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_status.count == $past(q_status.count) + 1'b1))
        else $error("queue count lost a pushed transaction");

endmodule
